@@ hw/rtl/fir_decimate_by_three_assert.svh @@
// Assertion macros for the decimating FIR.
// Each macro takes a label, a condition, a consequence and a message string.
`ifndef FIR_DECIMATE_BY_THREE_ASSERT_SVH
`define FIR_DECIMATE_BY_THREE_ASSERT_SVH

// Consequence holds in the same cycle as the condition.
`define FIR3_ASSERT_NOW(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Consequence holds in the cycle after the condition.
`define FIR3_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/fir3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fir3_pkg;

   localparam int TAPS       = 63;
   localparam int COEFF_BITS = 18;
   localparam int FRAC_SHIFT = COEFF_BITS - 1;
   localparam int IDX_BITS   = $clog2(TAPS);

   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic signed [COEFF_BITS-1:0] coef_type;

   localparam idx_type LAST_IDX = IDX_BITS'(TAPS - 1);

   // Hann-windowed sinc, cutoff 7600/48000, unit sum, signed Q1.17.
   // Entry 0 meets the oldest sample.
   localparam coef_type COEF_ROM [TAPS] = '{
      18'sd0,      -18'sd4,     -18'sd8,     18'sd14,     18'sd62,     18'sd67,
      -18'sd39,    -18'sd199,   -18'sd219,   18'sd38,     18'sd417,    18'sd505,
      18'sd38,     -18'sd703,   -18'sd972,   -18'sd257,   18'sd1033,   18'sd1678,
      18'sd719,    -18'sd1377,  -18'sd2728,  -18'sd1595,  18'sd1696,   18'sd4380,
      18'sd3298,   -18'sd1956,  -18'sd7553,  -18'sd7437,  18'sd2125,   18'sd18861,
      18'sd34898,  18'sd41503,  18'sd34898,  18'sd18861,  18'sd2125,   -18'sd7437,
      -18'sd7553,  -18'sd1956,  18'sd3298,   18'sd4380,   18'sd1696,   -18'sd1595,
      -18'sd2728,  -18'sd1377,  18'sd719,    18'sd1678,   18'sd1033,   -18'sd257,
      -18'sd972,   -18'sd703,   18'sd38,     18'sd505,    18'sd417,    18'sd38,
      -18'sd219,   -18'sd199,   -18'sd39,    18'sd67,     18'sd62,     -18'sd4,
      -18'sd8,     18'sd14,     18'sd0
   };

   function automatic coef_type coef_at(input idx_type idx);
      coef_type c;
      c = '0;
      if (idx <= LAST_IDX) begin
         c = COEF_ROM[idx];
      end
      return c;
   endfunction

   // Advance a ring index, wrapping after the last tap.
   function automatic idx_type next_idx(input idx_type idx);
      idx_type n;
      n = idx + IDX_BITS'(1);
      if (idx == LAST_IDX) begin
         n = '0;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fir3_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fir3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 63
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fir_decimate_by_three.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                              Direction  Carries
// request   req_valid req_stall req_in_sample  in         one mono Q1.15 sample
// response  rsp_valid rsp_stall rsp_out_sample out        one filtered Q1.15 sample
//
// A sample that does not start an output leaves req_stall low; one that does
// holds req_stall high through the 63-tap walk over the sample RAM read port,
// one multiply-accumulate per tap, plus the read, multiply and round stages.
// After reset, a 63-entry sweep clears the sample RAM while req_stall is high.
// The result sits in an output register, so a stalled response holds the
// next output only at its final rounding step.

module fir_decimate_by_three #(
   parameter int DECIMATION  = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed      [SAMPLE_BITS-1:0] rsp_out_sample
);

   localparam int PROD_BITS = SAMPLE_BITS + fir3_pkg::COEFF_BITS;
   localparam int ACC_BITS  = PROD_BITS + $clog2(fir3_pkg::TAPS);
   localparam int RND_BITS  = ACC_BITS + 1 - fir3_pkg::FRAC_SHIFT;
   localparam int PH_BITS   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

   localparam logic [PH_BITS-1:0] PH_LAST = PH_BITS'(DECIMATION - 1);
   localparam logic signed [ACC_BITS:0] ROUND_HALF =
      (ACC_BITS + 1)'(1) << (fir3_pkg::FRAC_SHIFT - 1);
   localparam logic signed [RND_BITS-1:0] SAT_HI =
      RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_BITS-1:0] SAT_LO = ~SAT_HI;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_RUN    = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   fir3_pkg::idx_type wr_pos_ff, wr_pos_in;
   logic [PH_BITS-1:0] phase_ff, phase_in;
   fir3_pkg::idx_type cnt_ff, cnt_in;
   fir3_pkg::idx_type rd_idx_ff, rd_idx_in;
   logic rd_vld_ff, rd_vld_in;
   logic rd_last_ff, rd_last_in;
   fir3_pkg::idx_type coef_sel_ff, coef_sel_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic prod_vld_ff, prod_vld_in;
   logic prod_last_ff, prod_last_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic req_fire;
   logic out_free;
   logic ram_wr_en;
   fir3_pkg::idx_type ram_wr_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic signed [ACC_BITS:0] biased;
   logic signed [RND_BITS-1:0] rounded;
   logic signed [SAMPLE_BITS-1:0] saturated;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Clear sweep and incoming samples share the write port.
   assign ram_wr_en   = (state_ff == ST_CLEAR) || req_fire;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? cnt_ff : wr_pos_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : req_in_sample;
   assign ram_rd_en   = (state_ff == ST_RUN);

   fir3_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(fir3_pkg::TAPS)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_idx_ff),
      .rd_data(ram_rd_data)
   );

   // Round half up, then clamp to full scale.
   always_comb begin
      biased  = (ACC_BITS + 1)'(acc_ff) + ROUND_HALF;
      rounded = $signed(biased[ACC_BITS:fir3_pkg::FRAC_SHIFT]);
      if (rounded > SAT_HI) begin
         saturated = SAMPLE_BITS'(SAT_HI);
      end else if (rounded < SAT_LO) begin
         saturated = SAMPLE_BITS'(SAT_LO);
      end else begin
         saturated = SAMPLE_BITS'(rounded);
      end
   end

   always_comb begin
      state_in      = state_ff;
      wr_pos_in     = wr_pos_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      // read -> multiply -> accumulate
      rd_vld_in    = (state_ff == ST_RUN);
      rd_last_in   = (cnt_ff == fir3_pkg::LAST_IDX);
      coef_sel_in  = cnt_ff;
      prod_vld_in  = rd_vld_ff;
      prod_last_in = rd_last_ff;
      prod_in      = $signed(ram_rd_data) * fir3_pkg::coef_at(coef_sel_ff);
      acc_in       = acc_ff;
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = fir3_pkg::next_idx(cnt_ff);
            if (cnt_ff == fir3_pkg::LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               wr_pos_in = fir3_pkg::next_idx(wr_pos_ff);
               phase_in  = (phase_ff == PH_LAST) ? '0 : phase_ff + PH_BITS'(1);
               if (phase_ff == '0) begin
                  // oldest sample sits just past the one written now
                  state_in  = ST_RUN;
                  rd_idx_in = fir3_pkg::next_idx(wr_pos_ff);
                  cnt_in    = '0;
                  acc_in    = '0;
               end
            end
         end
         ST_RUN: begin
            cnt_in    = fir3_pkg::next_idx(cnt_ff);
            rd_idx_in = fir3_pkg::next_idx(rd_idx_ff);
            if (cnt_ff == fir3_pkg::LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (prod_vld_ff && prod_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = saturated;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wr_pos_ff    <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff    <= rd_last_in;
      coef_sel_ff   <= coef_sel_in;
      prod_ff       <= prod_in;
      prod_last_ff  <= prod_last_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;

`include "fir_decimate_by_three_assert.svh"

   `FIR3_ASSERT_NEXT(a_skip_stays_idle, req_fire && (phase_ff != '0),
      state_ff == ST_IDLE, "sample off phase did not return to idle")

   `FIR3_ASSERT_NOW(a_mac_only_in_walk, prod_vld_ff,
      (state_ff == ST_RUN) || (state_ff == ST_DRAIN), "product outside tap walk")

   `FIR3_ASSERT_NOW(a_ring_index_range, 1'b1,
      (wr_pos_ff <= fir3_pkg::LAST_IDX) && (rd_idx_ff <= fir3_pkg::LAST_IDX),
      "ring index beyond last tap")

   `FIR3_ASSERT_NEXT(a_finish_loads_output, (state_ff == ST_FINISH) && out_free,
      rsp_valid && (state_ff == ST_IDLE), "finished sum not presented")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int DECIM     = 3;
   localparam int MAX_CYCLES = 1_000_000;
   localparam int DRAIN     = 100;
   localparam longint ROUND_HALF = longint'(1) <<< (fir3_pkg::FRAC_SHIFT - 1);

   typedef logic signed [15:0] sample_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   sample_type req_in_sample = '0;
   logic       rsp_stall = 1'b0;
   wire        req_stall;
   wire        rsp_valid;
   sample_type rsp_out_sample;

   fir_decimate_by_three u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Filter state mirrored from accepted requests.
   sample_type  history [fir3_pkg::TAPS];
   int unsigned next_slot = 0;
   int unsigned phase = 0;
   sample_type  pending_out [$];

   bit steady = 1'b0;
   int samples_in = 0;
   int outputs_seen = 0;
   int clipped_high = 0;
   int clipped_low = 0;
   int mismatches = 0;
   int cycles = 0;

   initial begin
      foreach (history[i]) history[i] = '0;
   end

   // Write the sample into the ring; on phase zero return the filtered output.
   function automatic bit filter_sample(input sample_type s, output sample_type y);
      longint      acc;
      longint      r;
      int unsigned idx;
      bit          fire;
      acc = 0;
      y = '0;
      history[next_slot] = s;
      next_slot = (next_slot == fir3_pkg::TAPS - 1) ? 0 : next_slot + 1;
      fire = (phase == 0);
      phase = (phase == DECIM - 1) ? 0 : phase + 1;
      if (!fire) begin
         return 1'b0;
      end
      for (int i = 0; i < fir3_pkg::TAPS; i++) begin
         idx = next_slot + i;
         if (idx >= fir3_pkg::TAPS) begin
            idx -= fir3_pkg::TAPS;
         end
         acc += longint'(fir3_pkg::COEF_ROM[i]) * longint'(history[idx]);
      end
      r = (acc + ROUND_HALF) >>> fir3_pkg::FRAC_SHIFT;
      if (r > 32767) begin
         r = 32767;
      end
      if (r < -32768) begin
         r = -32768;
      end
      y = sample_type'(r);
      return 1'b1;
   endfunction

   task automatic send_sample(input sample_type s);
      int unsigned gap;
      sample_type  y;
      gap = 0;
      if (!steady && $urandom_range(99) < 35) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_sample <= s;
      do @(posedge clock); while (req_stall);
      samples_in++;
      if (filter_sample(s, y)) begin
         pending_out = {pending_out, y};
      end
   endtask

   // Line up 63 near-full-scale samples with the coefficient signs so the
   // output that closes the burst lands far past full scale.
   task automatic send_aligned_burst(input bit negative);
      sample_type big_pos;
      sample_type big_neg;
      while (phase != 1) begin
         send_sample(sample_type'($urandom_range(200)) - 16'sd100);
      end
      for (int j = 0; j < fir3_pkg::TAPS; j++) begin
         big_pos = sample_type'($urandom_range(32767, 24000));
         big_neg = sample_type'(-int'($urandom_range(32768, 24000)));
         if ((fir3_pkg::COEF_ROM[j] >= 0) != negative) begin
            send_sample(big_pos);
         end else begin
            send_sample(big_neg);
         end
      end
   endtask

   // Impulse into silence, followed by six zero samples.
   task automatic test_startup_impulse();
      send_sample(16'sd32767);
      repeat (6) send_sample(16'sd0);
   endtask

   task automatic test_extremes();
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sd0);
      send_sample(sample_type'(16'h5555));
      send_sample(sample_type'(16'haaaa));
      send_sample(-16'sd32768);
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
   endtask

   task automatic test_overflow();
      send_aligned_burst(1'b0);
      send_aligned_burst(1'b1);
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (150) send_sample(sample_type'($urandom));
      steady = 1'b0;
   endtask

   task automatic test_random_audio(input int target);
      int         len;
      sample_type level;
      level = '0;
      while (samples_in < target) begin
         len = $urandom_range(60, 20);
         case ($urandom_range(9))
            0, 1: send_aligned_burst(1'($urandom_range(1)));
            2, 3, 4: repeat (len) send_sample(sample_type'($urandom));
            5, 6, 7: begin
               // random walk, roughly band-limited audio
               repeat (len) begin
                  level = level + sample_type'($urandom_range(4000)) - 16'sd2000;
                  send_sample(level);
               end
            end
            8: begin
               repeat (len) begin
                  send_sample($urandom_range(1) ? 16'sd32767 : -16'sd32768);
               end
            end
            default: repeat (len) send_sample(sample_type'($urandom_range(200)) - 16'sd100);
         endcase
      end
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 35);
   end

   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         outputs_seen++;
         if (pending_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("output %0d: unexpected sample %0d", outputs_seen, rsp_out_sample);
            end
         end else begin
            want = pending_out.pop_front();
            if (want == 16'sd32767) begin
               clipped_high++;
            end
            if (want == -16'sd32768) begin
               clipped_low++;
            end
            if (rsp_out_sample !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("output %0d: out_sample expected %0d, got %0d",
                           outputs_seen, want, rsp_out_sample);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d outputs outstanding",
                  cycles, pending_out.size());
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_startup_impulse();
      test_extremes();
      test_overflow();
      test_random_audio(700);
      test_back_to_back();
      test_random_audio(1430);
      drain_outputs();
      if (pending_out.size() != 0) begin
         mismatches += pending_out.size();
      end
      $display("summary: %0d samples in, %0d decimated outputs checked",
               samples_in, outputs_seen);
      $display("summary: %0d outputs clipped high, %0d clipped low, %0d mismatches",
               clipped_high, clipped_low, mismatches);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
